FILE: sv/rfe_pkg.sv
// Shared types and constants of the raster fill engine.
`default_nettype none

package rfe_pkg;

   // Fixed field widths
   localparam int COORD_W = 9;    // frame coordinates, set by the 9-bit size registers
   localparam int SPAN_W  = 18;   // signed clipping arithmetic
   localparam int SQ_W    = 32;   // squared distances and radius
   localparam int PIX_W   = 32;
   localparam int COUNT_W = 17;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   // Command kinds
   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_RECT   = 2'd1;
   localparam logic [1:0] KIND_CIRCLE = 2'd2;
   localparam logic [1:0] KIND_READ   = 2'd3;

   // Register indexes (byte address 4*index)
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] REG_BLUE_FIRST   = 2'd2;

   // Register reset values
   localparam logic [COORD_W-1:0] RST_FRAME_WIDTH  = 9'd256;
   localparam logic [COORD_W-1:0] RST_FRAME_HEIGHT = 9'd256;

   typedef struct packed {
      logic [COORD_W-1:0] frame_width;
      logic [COORD_W-1:0] frame_height;
      logic               blue_first;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] rect_width;
      logic [15:0] rect_height;
      logic [15:0] circle_radius;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
   } cmd_type;

endpackage

`default_nettype wire

FILE: sv/rfe_pixel_ram.sv
// Single-port synchronous pixel memory with registered read data.
`default_nettype none

module rfe_pixel_ram #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16
) (
   input  wire logic                     clock,
   input  wire logic                     mem_en,
   input  wire logic                     mem_we,
   input  wire logic [AW-1:0]            mem_addr,
   input  wire logic [rfe_pkg::PIX_W-1:0] mem_wdata,
   output logic      [rfe_pkg::PIX_W-1:0] mem_rdata
);

   logic [rfe_pkg::PIX_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (mem_en && mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_en && !mem_we) begin
         mem_rdata <= mem[mem_addr];
      end
   end

endmodule

`default_nettype wire

FILE: sv/rfe_csr.sv
// APB register block: frame size and byte order.
`default_nettype none

module rfe_csr (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [rfe_pkg::CSR_AW-1:0] paddr,
   input  wire logic [rfe_pkg::CSR_DW-1:0] pwdata,
   output logic      [rfe_pkg::CSR_DW-1:0] prdata,
   output logic                           pready,
   output rfe_pkg::cfg_type               cfg
);

   logic [rfe_pkg::COORD_W-1:0] frame_width_ff, frame_width_in;
   logic [rfe_pkg::COORD_W-1:0] frame_height_ff, frame_height_in;
   logic                        blue_first_ff, blue_first_in;
   logic [1:0]                  reg_idx;
   logic                        wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;

   // Register writes
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      blue_first_in   = blue_first_ff;
      if (wr_en) begin
         case (reg_idx)
            rfe_pkg::REG_FRAME_WIDTH: begin
               frame_width_in = pwdata[rfe_pkg::COORD_W-1:0];
            end
            rfe_pkg::REG_FRAME_HEIGHT: begin
               frame_height_in = pwdata[rfe_pkg::COORD_W-1:0];
            end
            rfe_pkg::REG_BLUE_FIRST: begin
               blue_first_in = pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= rfe_pkg::RST_FRAME_WIDTH;
         frame_height_ff <= rfe_pkg::RST_FRAME_HEIGHT;
         blue_first_ff   <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         blue_first_ff   <= blue_first_in;
      end
   end

   // Read-back
   always_comb begin
      case (reg_idx)
         rfe_pkg::REG_FRAME_WIDTH:  prdata = rfe_pkg::CSR_DW'(frame_width_ff);
         rfe_pkg::REG_FRAME_HEIGHT: prdata = rfe_pkg::CSR_DW'(frame_height_ff);
         rfe_pkg::REG_BLUE_FIRST:   prdata = rfe_pkg::CSR_DW'(blue_first_ff);
         default:                   prdata = '0;
      endcase
   end

   assign cfg.frame_width  = frame_width_ff;
   assign cfg.frame_height = frame_height_ff;
   assign cfg.blue_first   = blue_first_ff;

endmodule

`default_nettype wire

FILE: sv/rfe_seq.sv
// Command sequencer: clipping, setup multiplies, pixel scan and memory access.
`default_nettype none

module rfe_seq #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT,
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire rfe_pkg::cfg_type          cfg,
   input  wire logic                      start,
   input  wire rfe_pkg::cmd_type          req,
   output logic                           busy,
   output logic                           rsp_strobe,
   output logic [rfe_pkg::PIX_W-1:0]      rsp_pixel_word,
   output logic [rfe_pkg::COUNT_W-1:0]    rsp_pixels_written,
   output logic                           mem_en,
   output logic                           mem_we,
   output logic [AW-1:0]                  mem_addr,
   output logic [rfe_pkg::PIX_W-1:0]      mem_wdata,
   input  wire logic [rfe_pkg::PIX_W-1:0] mem_rdata
);

   localparam int SUMW  = ((AW > rfe_pkg::COORD_W) ? AW : rfe_pkg::COORD_W) + 1;
   localparam int CW    = rfe_pkg::COORD_W;
   localparam int SW    = rfe_pkg::SPAN_W;
   localparam int QW    = rfe_pkg::SQ_W;

   localparam logic [AW-1:0]        INIT_LAST = AW'(DEPTH - 1);
   localparam logic [12:0]          MAXW_L    = 13'(MAX_WIDTH);
   localparam logic [12:0]          MAXH_L    = 13'(MAX_HEIGHT);
   localparam logic signed [SW-1:0] S_ZERO    = '0;
   localparam logic signed [SW-1:0] S_ONE     = SW'(1);

   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_CLIP   = 3'd2;
   localparam logic [2:0] ST_MUL    = 3'd3;
   localparam logic [2:0] ST_SCAN   = 3'd4;
   localparam logic [2:0] ST_READ   = 3'd5;
   localparam logic [2:0] ST_RDDATA = 3'd6;
   localparam logic [2:0] ST_DONE   = 3'd7;

   // Control registers
   logic [2:0]              state_ff, state_in;
   logic [AW-1:0]           init_cnt_ff, init_cnt_in;
   logic [1:0]              mul_step_ff, mul_step_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;

   // Command and scan registers
   rfe_pkg::cmd_type        cmd_ff, cmd_in;
   logic [rfe_pkg::PIX_W-1:0] word_ff, word_in;
   logic [CW-1:0]           w_ff, w_in, h_ff, h_in;
   logic signed [SW-1:0]    xs_ff, xs_in, xe_ff, xe_in, ys_ff, ys_in, ye_ff, ye_in;
   logic signed [SW-1:0]    dx0_ff, dx0_in, dy0_ff, dy0_in;
   logic signed [SW-1:0]    dx_ff, dx_in, dy_ff, dy_in;
   logic [QW-1:0]           dx2_row_ff, dx2_row_in, dx2_ff, dx2_in, dy2_ff, dy2_in;
   logic [QW-1:0]           rr_ff, rr_in;
   logic [AW-1:0]           row_base_ff, row_base_in;
   logic [CW-1:0]           x_ff, x_in, y_ff, y_in;
   logic [rfe_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [rfe_pkg::PIX_W-1:0]   rsp_word_ff, rsp_word_in;
   logic [rfe_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // Combinational helpers
   logic [CW-1:0]           used_w, used_h;
   logic [rfe_pkg::PIX_W-1:0] color;
   logic signed [SW-1:0]    px_e, py_e, rw_e, rh_e, rad_e, w_e, h_e;
   logic signed [SW-1:0]    lo_x, hi_x, lo_y, hi_y;
   logic signed [SW-1:0]    clip_xs, clip_xe, clip_ys, clip_ye;
   logic                    shape_empty, clip_empty;
   logic signed [SW-1:0]    mul_a, mul_b;
   logic signed [2*SW-1:0]  mul_p;
   logic [SUMW-1:0]         scan_sum;
   logic [AW-1:0]           scan_addr;
   logic [QW:0]             dist_sum;
   logic                    in_disc, last_x, last_y;
   logic [QW-1:0]           dx_step, dy_step;

   // Frame size in use, clamped to the store
   assign used_w = ({4'b0, cfg.frame_width} > MAXW_L) ? MAXW_L[CW-1:0] : cfg.frame_width;
   assign used_h = ({4'b0, cfg.frame_height} > MAXH_L) ? MAXH_L[CW-1:0] : cfg.frame_height;

   // Byte order of the stored word
   assign color = cfg.blue_first ? {req.alpha, req.red, req.green, req.blue}
                                 : {req.alpha, req.blue, req.green, req.red};

   // Signed views of the latched command
   assign px_e  = SW'($signed(cmd_ff.pos_x));
   assign py_e  = SW'($signed(cmd_ff.pos_y));
   assign rw_e  = SW'($signed(cmd_ff.rect_width));
   assign rh_e  = SW'($signed(cmd_ff.rect_height));
   assign rad_e = SW'($signed(cmd_ff.circle_radius));
   assign w_e   = $signed({{(SW-CW){1'b0}}, w_ff});
   assign h_e   = $signed({{(SW-CW){1'b0}}, h_ff});

   // Clip the bounding box to the frame (inclusive bounds)
   always_comb begin
      lo_x        = S_ZERO;
      hi_x        = S_ZERO;
      lo_y        = S_ZERO;
      hi_y        = S_ZERO;
      clip_xs     = S_ZERO;
      clip_xe     = w_e - S_ONE;
      clip_ys     = S_ZERO;
      clip_ye     = h_e - S_ONE;
      shape_empty = 1'b0;
      case (cmd_ff.kind)
         rfe_pkg::KIND_CLEAR: begin
         end
         rfe_pkg::KIND_RECT: begin
            hi_x        = px_e + rw_e;
            hi_y        = py_e + rh_e;
            clip_xs     = (px_e > S_ZERO) ? px_e : S_ZERO;
            clip_ys     = (py_e > S_ZERO) ? py_e : S_ZERO;
            clip_xe     = ((hi_x < w_e) ? hi_x : w_e) - S_ONE;
            clip_ye     = ((hi_y < h_e) ? hi_y : h_e) - S_ONE;
            shape_empty = (rw_e <= S_ZERO) || (rh_e <= S_ZERO);
         end
         rfe_pkg::KIND_CIRCLE: begin
            lo_x        = px_e - rad_e;
            hi_x        = px_e + rad_e;
            lo_y        = py_e - rad_e;
            hi_y        = py_e + rad_e;
            clip_xs     = (lo_x > S_ZERO) ? lo_x : S_ZERO;
            clip_ys     = (lo_y > S_ZERO) ? lo_y : S_ZERO;
            clip_xe     = (hi_x < w_e - S_ONE) ? hi_x : w_e - S_ONE;
            clip_ye     = (hi_y < h_e - S_ONE) ? hi_y : h_e - S_ONE;
            shape_empty = (rad_e <= S_ZERO);
         end
         default: begin
            clip_xs     = px_e;
            clip_xe     = px_e;
            clip_ys     = py_e;
            clip_ye     = py_e;
            shape_empty = (px_e < S_ZERO) || (py_e < S_ZERO) || (px_e >= w_e) || (py_e >= h_e);
         end
      endcase
      clip_empty = shape_empty || (clip_xs > clip_xe) || (clip_ys > clip_ye);
   end

   // Shared setup multiplier: row base, then the three squares
   always_comb begin
      case (mul_step_ff)
         2'd0: begin
            mul_a = ys_ff;
            mul_b = w_e;
         end
         2'd1: begin
            mul_a = dx0_ff;
            mul_b = dx0_ff;
         end
         2'd2: begin
            mul_a = dy0_ff;
            mul_b = dy0_ff;
         end
         default: begin
            mul_a = rad_e;
            mul_b = rad_e;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // Scan address and disc test
   assign scan_sum  = SUMW'(row_base_ff) + SUMW'(x_ff);
   assign scan_addr = scan_sum[AW-1:0];
   assign dist_sum  = {1'b0, dx2_ff} + {1'b0, dy2_ff};
   assign in_disc   = (cmd_ff.kind != rfe_pkg::KIND_CIRCLE) || (dist_sum <= {1'b0, rr_ff});
   assign last_x    = (x_ff == xe_ff[CW-1:0]);
   assign last_y    = (y_ff == ye_ff[CW-1:0]);
   // (d+1)^2 = d^2 + 2d + 1, kept modulo 2^32
   assign dx_step   = {QW'(dx_ff) << 1} | QW'(1);
   assign dy_step   = {QW'(dy_ff) << 1} | QW'(1);

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      init_cnt_in   = init_cnt_ff;
      mul_step_in   = mul_step_ff;
      rsp_strobe_in = 1'b0;
      cmd_in        = cmd_ff;
      word_in       = word_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      xs_in         = xs_ff;
      xe_in         = xe_ff;
      ys_in         = ys_ff;
      ye_in         = ye_ff;
      dx0_in        = dx0_ff;
      dy0_in        = dy0_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      dx2_row_in    = dx2_row_ff;
      dx2_in        = dx2_ff;
      dy2_in        = dy2_ff;
      rr_in         = rr_ff;
      row_base_in   = row_base_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      count_in      = count_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_count_in  = rsp_count_ff;
      mem_en        = 1'b0;
      mem_we        = 1'b0;
      mem_addr      = scan_addr;
      mem_wdata     = word_ff;
      case (state_ff)
         // Clearing pass over the whole store after reset
         ST_INIT: begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = init_cnt_ff;
            mem_wdata = '0;
            if (init_cnt_ff == INIT_LAST) begin
               state_in = ST_IDLE;
            end else begin
               init_cnt_in = init_cnt_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd_in      = req;
               word_in     = color;
               w_in        = used_w;
               h_in        = used_h;
               count_in    = '0;
               mul_step_in = 2'd0;
               state_in    = ST_CLIP;
            end
         end
         ST_CLIP: begin
            xs_in    = clip_xs;
            xe_in    = clip_xe;
            ys_in    = clip_ys;
            ye_in    = clip_ye;
            state_in = clip_empty ? ST_DONE : ST_MUL;
         end
         ST_MUL: begin
            mul_step_in = mul_step_ff + 2'd1;
            case (mul_step_ff)
               2'd0: begin
                  row_base_in = mul_p[AW-1:0];
                  dx0_in      = xs_ff - px_e;
                  dy0_in      = ys_ff - py_e;
               end
               2'd1: begin
                  dx2_row_in = mul_p[QW-1:0];
               end
               2'd2: begin
                  dy2_in = mul_p[QW-1:0];
               end
               default: begin
                  rr_in    = mul_p[QW-1:0];
                  x_in     = xs_ff[CW-1:0];
                  y_in     = ys_ff[CW-1:0];
                  dx_in    = dx0_ff;
                  dy_in    = dy0_ff;
                  dx2_in   = dx2_row_ff;
                  state_in = (cmd_ff.kind == rfe_pkg::KIND_READ) ? ST_READ : ST_SCAN;
               end
            endcase
         end
         // One pixel per cycle, row by row
         ST_SCAN: begin
            mem_en   = in_disc;
            mem_we   = in_disc;
            count_in = count_ff + rfe_pkg::COUNT_W'(in_disc);
            if (last_x) begin
               x_in   = xs_ff[CW-1:0];
               dx_in  = dx0_ff;
               dx2_in = dx2_row_ff;
               if (last_y) begin
                  state_in = ST_DONE;
               end else begin
                  y_in        = y_ff + CW'(1);
                  dy_in       = dy_ff + S_ONE;
                  dy2_in      = dy2_ff + dy_step;
                  row_base_in = row_base_ff + AW'(w_ff);
               end
            end else begin
               x_in   = x_ff + CW'(1);
               dx_in  = dx_ff + S_ONE;
               dx2_in = dx2_ff + dx_step;
            end
         end
         ST_READ: begin
            mem_en   = 1'b1;
            state_in = ST_RDDATA;
         end
         ST_RDDATA: begin
            rsp_strobe_in = 1'b1;
            rsp_word_in   = mem_rdata;
            rsp_count_in  = '0;
            state_in      = ST_IDLE;
         end
         ST_DONE: begin
            rsp_strobe_in = 1'b1;
            rsp_word_in   = '0;
            rsp_count_in  = count_ff;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         init_cnt_ff   <= '0;
         mul_step_ff   <= 2'd0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_cnt_ff   <= init_cnt_in;
         mul_step_ff   <= mul_step_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      word_ff      <= word_in;
      w_ff         <= w_in;
      h_ff         <= h_in;
      xs_ff        <= xs_in;
      xe_ff        <= xe_in;
      ys_ff        <= ys_in;
      ye_ff        <= ye_in;
      dx0_ff       <= dx0_in;
      dy0_ff       <= dy0_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      dx2_row_ff   <= dx2_row_in;
      dx2_ff       <= dx2_in;
      dy2_ff       <= dy2_in;
      rr_ff        <= rr_in;
      row_base_ff  <= row_base_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      count_ff     <= count_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_pixel_word     = rsp_word_ff;
   assign rsp_pixels_written = rsp_count_ff;

   // Checks
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("result strobe held for more than one cycle");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_INIT || state_ff == ST_SCAN))
      else $error("pixel write outside clear pass or scan");

   a_scan_in_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (x_ff < w_ff && y_ff < h_ff))
      else $error("scan position outside the frame");

   a_word_from_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_word_ff != '0) |-> ($past(state_ff) == ST_RDDATA))
      else $error("nonzero pixel word on a non-read command");

endmodule

`default_nettype wire

FILE: sv/raster_fill_engine.sv
// Top level of the raster fill engine: framebuffer with fill and read commands.
//
//   channel   ports                               handshake
//   --------  ----------------------------------  ------------------------------
//   request   req_kind .. req_alpha               taken when start & !busy
//   result    rsp_pixel_word, rsp_pixels_written  valid one cycle on rsp_strobe
//   config    psel penable pwrite paddr pwdata    APB, write at access phase
//
// A request runs through clipping, the setup multiplies and then the scan, or
// one memory read for a read; an empty shape goes from clipping to the strobe.
// A clear scans W*H pixels, a rectangle its clipped area, a circle its clipped
// bounding box, one pixel per cycle through the single memory port. The next
// request can be taken in the strobe cycle. After reset the store is cleared
// with busy high. Results cannot be stalled; one request is in flight at a time.
`default_nettype none

module raster_fill_engine #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [1:0]                  req_kind,
   input  wire logic signed [15:0]          req_pos_x,
   input  wire logic signed [15:0]          req_pos_y,
   input  wire logic signed [15:0]          req_rect_width,
   input  wire logic signed [15:0]          req_rect_height,
   input  wire logic signed [15:0]          req_circle_radius,
   input  wire logic [7:0]                  req_red,
   input  wire logic [7:0]                  req_green,
   input  wire logic [7:0]                  req_blue,
   input  wire logic [7:0]                  req_alpha,
   // result channel
   output logic                             rsp_strobe,
   output logic [rfe_pkg::PIX_W-1:0]        rsp_pixel_word,
   output logic [rfe_pkg::COUNT_W-1:0]      rsp_pixels_written,
   // configuration port
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [rfe_pkg::CSR_AW-1:0]  paddr,
   input  wire logic [rfe_pkg::CSR_DW-1:0]  pwdata,
   output logic      [rfe_pkg::CSR_DW-1:0]  prdata,
   output logic                             pready
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   rfe_pkg::cfg_type          cfg;
   rfe_pkg::cmd_type          req;
   logic                      mem_en;
   logic                      mem_we;
   logic [AW-1:0]             mem_addr;
   logic [rfe_pkg::PIX_W-1:0] mem_wdata;
   logic [rfe_pkg::PIX_W-1:0] mem_rdata;

   // Pack the request fields
   assign req.kind          = req_kind;
   assign req.pos_x         = req_pos_x;
   assign req.pos_y         = req_pos_y;
   assign req.rect_width    = req_rect_width;
   assign req.rect_height   = req_rect_height;
   assign req.circle_radius = req_circle_radius;
   assign req.red           = req_red;
   assign req.green         = req_green;
   assign req.blue          = req_blue;
   assign req.alpha         = req_alpha;

   rfe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rfe_seq #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_seq (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .start              (start),
      .req                (req),
      .busy               (busy),
      .rsp_strobe         (rsp_strobe),
      .rsp_pixel_word     (rsp_pixel_word),
      .rsp_pixels_written (rsp_pixels_written),
      .mem_en             (mem_en),
      .mem_we             (mem_we),
      .mem_addr           (mem_addr),
      .mem_wdata          (mem_wdata),
      .mem_rdata          (mem_rdata)
   );

   rfe_pixel_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock     (clock),
      .mem_en    (mem_en),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

endmodule

`default_nettype wire

FILE: bench/tb_raster_fill_engine.sv
// Testbench for raster_fill_engine: draw requests checked against a framebuffer predictor.

module tb_raster_fill_engine;

   localparam int FRAME_MAX_W   = 256;
   localparam int FRAME_MAX_H   = 256;
   localparam int STORE_DEPTH   = FRAME_MAX_W * FRAME_MAX_H;
   localparam int IDLE_LIMIT    = 300000;  // watchdog limit, above the full-frame scan
   localparam int SETTLE_CYCLES = 24;

   typedef struct packed {
      logic [rfe_pkg::PIX_W-1:0]   pixel_word;
      logic [rfe_pkg::COUNT_W-1:0] pixels_written;
   } fill_result_type;

   logic                         clock   = 1'b0;
   logic                         reset   = 1'b1;
   logic                         start   = 1'b0;
   logic                         busy;
   rfe_pkg::cmd_type             req     = '0;
   logic                         rsp_strobe;
   logic [rfe_pkg::PIX_W-1:0]    rsp_pixel_word;
   logic [rfe_pkg::COUNT_W-1:0]  rsp_pixels_written;
   logic                         psel    = 1'b0;
   logic                         penable = 1'b0;
   logic                         pwrite  = 1'b0;
   logic [rfe_pkg::CSR_AW-1:0]   paddr   = '0;
   logic [rfe_pkg::CSR_DW-1:0]   pwdata  = '0;
   logic [rfe_pkg::CSR_DW-1:0]   prdata;
   logic                         pready;

   // predictor state: framebuffer copy and register shadow
   bit   [rfe_pkg::PIX_W-1:0]    frame_mem [0:STORE_DEPTH-1];
   rfe_pkg::cfg_type             cfg_shadow = {rfe_pkg::RST_FRAME_WIDTH,
                                               rfe_pkg::RST_FRAME_HEIGHT, 1'b0};

   rfe_pkg::cmd_type             pending_cmds [$];
   fill_result_type              results_due [$];
   logic                         req_fire = 1'b0;
   int                           burst_left = 1;
   int                           gap_left = 0;
   int                           idle_cycles = 0;
   int                           mismatches = 0;

   raster_fill_engine #(
      .MAX_WIDTH (FRAME_MAX_W),
      .MAX_HEIGHT(FRAME_MAX_H)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req.kind),
      .req_pos_x          (req.pos_x),
      .req_pos_y          (req.pos_y),
      .req_rect_width     (req.rect_width),
      .req_rect_height    (req.rect_height),
      .req_circle_radius  (req.circle_radius),
      .req_red            (req.red),
      .req_green          (req.green),
      .req_blue           (req.blue),
      .req_alpha          (req.alpha),
      .rsp_strobe         (rsp_strobe),
      .rsp_pixel_word     (rsp_pixel_word),
      .rsp_pixels_written (rsp_pixels_written),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always #2 clock = ~clock;

   // Apply one request to the framebuffer copy and return the result it owes
   function automatic fill_result_type paint_command(rfe_pkg::cmd_type c);
      int                        w, h, px, py, rw, rh, rad, x0, y0, x1, y1, x, y;
      longint                    dx, dy, rr;
      logic [rfe_pkg::PIX_W-1:0] word;
      int unsigned               count;
      fill_result_type           res;
      w = cfg_shadow.frame_width;
      h = cfg_shadow.frame_height;
      if (w > FRAME_MAX_W) w = FRAME_MAX_W;
      if (h > FRAME_MAX_H) h = FRAME_MAX_H;
      px  = $signed(c.pos_x);
      py  = $signed(c.pos_y);
      rw  = $signed(c.rect_width);
      rh  = $signed(c.rect_height);
      rad = $signed(c.circle_radius);
      count = 0;
      res = '0;
      word = cfg_shadow.blue_first ? {c.alpha, c.red, c.green, c.blue}
                                   : {c.alpha, c.blue, c.green, c.red};
      case (c.kind)
         rfe_pkg::KIND_CLEAR: begin
            for (y = 0; y < h; y++)
               for (x = 0; x < w; x++) begin
                  frame_mem[y * w + x] = word;
                  count++;
               end
         end
         rfe_pkg::KIND_RECT: begin
            if (rw > 0 && rh > 0) begin
               x0 = (px > 0) ? px : 0;
               y0 = (py > 0) ? py : 0;
               x1 = (px + rw < w) ? px + rw : w;
               y1 = (py + rh < h) ? py + rh : h;
               for (y = y0; y < y1; y++)
                  for (x = x0; x < x1; x++) begin
                     frame_mem[y * w + x] = word;
                     count++;
                  end
            end
         end
         rfe_pkg::KIND_CIRCLE: begin
            if (rad > 0) begin
               rr = longint'(rad) * rad;
               x0 = (px - rad > 0) ? px - rad : 0;
               y0 = (py - rad > 0) ? py - rad : 0;
               x1 = (px + rad < w - 1) ? px + rad : w - 1;
               y1 = (py + rad < h - 1) ? py + rad : h - 1;
               for (y = y0; y <= y1; y++)
                  for (x = x0; x <= x1; x++) begin
                     dx = longint'(x) - px;
                     dy = longint'(y) - py;
                     if (dx * dx + dy * dy <= rr) begin
                        frame_mem[y * w + x] = word;
                        count++;
                     end
                  end
            end
         end
         default: begin
            if (px >= 0 && py >= 0 && px < w && py < h)
               res.pixel_word = frame_mem[py * w + px];
         end
      endcase
      res.pixels_written = count[rfe_pkg::COUNT_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      $display("MISMATCH at %0t: %s expected %h got %h", $realtime, what, want, got);
   endtask

   // Request driver: bursts of requests with random gaps between them
   always @(negedge clock) begin : drive_proc
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_cmds.size() != 0) begin
            req   <= pending_cmds.pop_front();
            start <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            end else begin
               burst_left--;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: register shadow, prediction on accept, result check, watchdog
   always @(posedge clock) begin : watch_proc
      fill_result_type due;
      bit              moved;
      moved = 1'b0;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= start && !busy;
         if (psel && penable && pwrite && pready) begin
            case (paddr[rfe_pkg::CSR_AW-1:2])
               rfe_pkg::REG_FRAME_WIDTH:
                  cfg_shadow.frame_width  = pwdata[rfe_pkg::COORD_W-1:0];
               rfe_pkg::REG_FRAME_HEIGHT:
                  cfg_shadow.frame_height = pwdata[rfe_pkg::COORD_W-1:0];
               rfe_pkg::REG_BLUE_FIRST:
                  cfg_shadow.blue_first   = pwdata[0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            results_due.insert(results_due.size(), paint_command(req));
            moved = 1'b1;
         end
         if (rsp_strobe) begin
            moved = 1'b1;
            if (results_due.size() == 0) begin
               report_mismatch("unexpected result, pixel_word", '0, rsp_pixel_word);
            end else begin
               due = results_due.pop_front();
               if (rsp_pixel_word !== due.pixel_word)
                  report_mismatch("pixel_word", due.pixel_word, rsp_pixel_word);
               if (rsp_pixels_written !== due.pixels_written)
                  report_mismatch("pixels_written", 32'(due.pixels_written),
                                  32'(rsp_pixels_written));
            end
         end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("** raster_fill_engine: FAILED **");
         $finish;
      end
   end

   // One APB write: setup cycle, then access cycle until pready
   task automatic csr_write(logic [1:0] index, logic [rfe_pkg::CSR_DW-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Block idle: all requests sent and answered
   task automatic wait_quiet();
      do @(posedge clock);
      while (pending_cmds.size() != 0 || start || results_due.size() != 0 || busy);
   endtask

   task automatic set_frame(int unsigned fw, int unsigned fh, bit bf);
      wait_quiet();
      csr_write(rfe_pkg::REG_FRAME_WIDTH, fw);
      csr_write(rfe_pkg::REG_FRAME_HEIGHT, fh);
      csr_write(rfe_pkg::REG_BLUE_FIRST, rfe_pkg::CSR_DW'(bf));
   endtask

   task automatic queue_cmd(logic [1:0] kind, int px, int py, int rw, int rh, int rad,
                            logic [31:0] rgba);
      rfe_pkg::cmd_type c;
      c.kind          = kind;
      c.pos_x         = 16'(px);
      c.pos_y         = 16'(py);
      c.rect_width    = 16'(rw);
      c.rect_height   = 16'(rh);
      c.circle_radius = 16'(rad);
      {c.red, c.green, c.blue, c.alpha} = rgba;
      pending_cmds.insert(pending_cmds.size(), c);
   endtask

   // Mostly values near the frame, sometimes the whole 16-bit range
   function automatic int pick16(int lo, int hi);
      if ($urandom_range(0, 3) == 0)
         return $signed(16'($urandom));
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   task automatic queue_random(int count, int w, int h);
      logic [1:0] kind;
      int         span;
      span = ((w > h) ? w : h) / 2 + 3;
      repeat (count) begin
         case ($urandom_range(0, 9))
            0:       kind = rfe_pkg::KIND_CLEAR;
            1, 2, 3: kind = rfe_pkg::KIND_RECT;
            4, 5, 6: kind = rfe_pkg::KIND_CIRCLE;
            default: kind = rfe_pkg::KIND_READ;
         endcase
         queue_cmd(kind, pick16(-4, w + 4), pick16(-4, h + 4), pick16(-2, w + 2),
                   pick16(-2, h + 2), pick16(-2, span), $urandom);
      end
   endtask

   // Stimulus sequence
   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // full frame: clipping, empty shapes, reads in and out of range
      set_frame(256, 256, 1'b0);
      queue_cmd(rfe_pkg::KIND_READ, 0, 0, 0, 0, 0, '0);
      queue_cmd(rfe_pkg::KIND_RECT, 250, 250, 100, 100, 0, 32'h11223344);
      queue_cmd(rfe_pkg::KIND_RECT, -32768, -32768, 32767, 32767, 0, 32'h55667788);
      queue_cmd(rfe_pkg::KIND_RECT, 5, 5, 0, 10, 0, 32'hffffffff);
      queue_cmd(rfe_pkg::KIND_RECT, 5, 5, 10, -32768, 0, 32'hffffffff);
      queue_cmd(rfe_pkg::KIND_CIRCLE, 0, 0, 0, 0, 3, 32'h00ff00ff);
      queue_cmd(rfe_pkg::KIND_CIRCLE, 10, 10, 0, 0, 0, 32'hffffffff);
      queue_cmd(rfe_pkg::KIND_CIRCLE, 10, 10, 0, 0, -32768, 32'hffffffff);
      queue_cmd(rfe_pkg::KIND_READ, 255, 255, 0, 0, 0, '0);
      queue_cmd(rfe_pkg::KIND_READ, 1, 2, 0, 0, 0, '0);
      queue_cmd(rfe_pkg::KIND_READ, -1, 0, 0, 0, 0, '0);
      queue_cmd(rfe_pkg::KIND_READ, 256, 3, 0, 0, 0, '0);
      queue_cmd(rfe_pkg::KIND_READ, 32767, -32768, 0, 0, 0, '0);
      // whole frame in one rectangle: largest pixel count
      queue_cmd(rfe_pkg::KIND_RECT, 0, 0, 32767, 32767, 0, 32'hffffffff);
      queue_cmd(rfe_pkg::KIND_READ, 128, 128, 0, 0, 0, '0);

      // empty frame: nothing written, reads give zero
      set_frame(0, 5, 1'b1);
      queue_cmd(rfe_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 32'h01020304);
      queue_cmd(rfe_pkg::KIND_RECT, 0, 0, 4, 4, 0, 32'h01020304);
      queue_cmd(rfe_pkg::KIND_READ, 0, 0, 0, 0, 0, '0);

      // oversized width clamps to the maximum, one row, blue first
      set_frame(511, 1, 1'b1);
      queue_cmd(rfe_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 32'h01020304);
      queue_cmd(rfe_pkg::KIND_CIRCLE, 100, 0, 0, 0, 32767, 32'ha0b0c0d0);
      queue_cmd(rfe_pkg::KIND_READ, 255, 0, 0, 0, 0, '0);
      queue_cmd(rfe_pkg::KIND_READ, 0, 1, 0, 0, 0, '0);

      // one column: old contents read back with the new stride
      set_frame(1, 256, 1'b0);
      queue_cmd(rfe_pkg::KIND_CIRCLE, 0, 128, 0, 0, 2, 32'h00000000);
      queue_cmd(rfe_pkg::KIND_READ, 0, 127, 0, 0, 0, '0);
      queue_cmd(rfe_pkg::KIND_READ, 0, 200, 0, 0, 0, '0);

      // random requests over a spread of small frame shapes
      set_frame(16, 12, 1'b0);
      queue_random(15, 16, 12);
      set_frame(256, 2, 1'b1);
      queue_random(15, 256, 2);
      set_frame(2, 256, 1'($urandom_range(0, 1)));
      queue_random(15, 2, 256);
      set_frame(1, 1, 1'b1);
      queue_random(10, 1, 1);
      set_frame($urandom_range(3, 24), $urandom_range(3, 24), 1'($urandom_range(0, 1)));
      queue_random(20, 24, 24);

      wait_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("** raster_fill_engine: PASSED **");
      end else begin
         $display("** raster_fill_engine: FAILED **");
      end
      $finish;
   end

endmodule
